FILE: hdl/utf8d_pkg.sv
// shared types, constants and helpers for the utf-8 byte range decoder
`default_nettype none

package utf8d_pkg;

    localparam int RANGE_LEN_BITS = 24;
    localparam int BAL_W          = RANGE_LEN_BITS + 3;
    localparam int CODE_W         = 21;

    // lead pattern masks and match values
    localparam logic [7:0] LEAD1_MASK = 8'd128;
    localparam logic [7:0] LEAD2_MASK = 8'd224;
    localparam logic [7:0] LEAD2_VAL  = 8'd192;
    localparam logic [7:0] LEAD3_MASK = 8'd240;
    localparam logic [7:0] LEAD3_VAL  = 8'd224;
    localparam logic [7:0] LEAD4_MASK = 8'd248;
    localparam logic [7:0] LEAD4_VAL  = 8'd240;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LEAD_ERR = 2'd1,
        STATUS_LEN_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code_point;
        logic              has_code;
        t_status           status;
        logic              range_end;
    } t_result;

    // announced length of a lead-pattern byte, zero when it has none
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & LEAD1_MASK) == 8'd0)            len = 3'd1;
        else if ((b & LEAD2_MASK) == LEAD2_VAL)  len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_VAL)  len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_VAL)  len = 3'd4;
        else                                     len = 3'd0;
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_byte_range_decoder.sv
// top level of the utf-8 byte range decoder: input stage, decode core, result register
`default_nettype none

// usage
//   slave channel: one byte of an encoded text range per item, tlast on the
//   range's final byte. master channel: zero or one result per byte, giving
//   a completed code point, a lead error, or the closing status of a range
//   (tlast set). a range whose closing status is a length mismatch must have
//   all of its codes discarded by the consumer.
// path: a byte is held in the input register, decoded by the core and captured
//   in the result register, from which its result is offered.
// throughput: one byte per cycle while results are taken; the decode state update is a
//   single shallow step per byte and the result register lets a new byte
//   in whenever the previous result is taken in the same cycle.
// stall: when the receiver holds tready low with a result waiting, the
//   input register keeps its byte and tready on the slave side drops once
//   that register is full; nothing is lost or repeated.
// reset: synchronous, active low; clears both valid flags and all range
//   state (pending count, accumulator, balance, stop and error flags).
module utf8_byte_range_decoder
    import utf8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,   // last_byte
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [23:0] o_m_axis_tdata,   // [20:0] code_point, [21] has_code, [23:22] status
    output      logic        o_m_axis_tlast    // range_end
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_has;
    t_status           r_out_status;
    logic              r_out_end;

    logic    out_free;
    logic    step;
    t_result res;

    // the result register can take a new value when empty or being drained
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    utf8d_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.emit) begin
            r_out_code   <= res.code_point;
            r_out_has    <= res.has_code;
            r_out_status <= res.status;
            r_out_end    <= res.range_end;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_status, r_out_has, r_out_code};
    assign o_m_axis_tlast  = r_out_end;

    // a result with no code mid-range can only be a lead error
    a_bare_is_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has && !r_out_end) |-> (r_out_status == STATUS_LEAD_ERR))
        else $error("result without code or range end is not a lead error");

    // code field is zero unless a code point completed
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> (r_out_code == '0))
        else $error("code point set without has_code");

    // a waiting byte is never dropped while the result side is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte lost during stall");

endmodule

`default_nettype wire

FILE: hdl/utf8d_core.sv
// per-range decode state and the single-byte decode step
`default_nettype none

module utf8d_core
    import utf8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output t_result         o_result
);

    logic [1:0]        r_pending, n_pending;
    logic [CODE_W-1:0] r_acc, n_acc;
    logic [BAL_W-1:0]  r_bal, n_bal;
    logic              r_stopped, n_stopped;
    logic              r_err, n_err;

    logic [2:0]        len;
    logic [CODE_W-1:0] payload;
    logic [CODE_W-1:0] acc_shift;
    logic              has;
    logic              emit;
    logic [CODE_W-1:0] code;
    t_status           status;

    always_comb begin
        len       = lead_len(i_data_byte);
        acc_shift = {r_acc[CODE_W-7:0], i_data_byte[5:0]};
        case (len)
            3'd1:    payload = {{(CODE_W-7){1'b0}}, i_data_byte[6:0]};
            3'd2:    payload = {{(CODE_W-5){1'b0}}, i_data_byte[4:0]};
            3'd3:    payload = {{(CODE_W-4){1'b0}}, i_data_byte[3:0]};
            default: payload = {{(CODE_W-3){1'b0}}, i_data_byte[2:0]};
        endcase

        n_stopped = r_stopped | (i_data_byte == 8'd0);
        n_err     = r_err;
        n_pending = r_pending;
        n_acc     = r_acc;
        has       = 1'b0;
        emit      = 1'b0;
        code      = '0;

        // balance: add announced length unless stopped, less one per byte
        n_bal = r_bal + (n_stopped ? {BAL_W{1'b0}} : {{(BAL_W-3){1'b0}}, len})
                - {{(BAL_W-1){1'b0}}, 1'b1};

        if (n_stopped) begin
            n_pending = 2'd0;
            n_acc     = '0;
        end else if (!r_err) begin
            if (r_pending != 2'd0) begin
                n_acc     = acc_shift;
                n_pending = r_pending - 2'd1;
                if (n_pending == 2'd0) begin
                    has   = 1'b1;
                    code  = acc_shift;
                    n_acc = '0;
                end
            end else if (len == 3'd0) begin
                n_err = 1'b1;
                emit  = 1'b1;
            end else if (len == 3'd1) begin
                has  = 1'b1;
                code = payload;
            end else begin
                n_acc     = payload;
                n_pending = 2'(len - 3'd1);
            end
        end

        if (has) begin
            emit = 1'b1;
        end

        if (i_last_byte) begin
            emit = 1'b1;
            if ((n_bal != '0) || (n_pending != 2'd0)) begin
                status = STATUS_LEN_ERR;
            end else begin
                status = n_err ? STATUS_LEAD_ERR : STATUS_OK;
            end
            // range closes: start afresh
            n_pending = 2'd0;
            n_acc     = '0;
            n_bal     = '0;
            n_stopped = 1'b0;
            n_err     = 1'b0;
        end else begin
            status = n_err ? STATUS_LEAD_ERR : STATUS_OK;
        end

        o_result.emit       = emit;
        o_result.code_point = code;
        o_result.has_code   = has;
        o_result.status     = status;
        o_result.range_end  = i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_acc     <= '0;
            r_bal     <= '0;
            r_stopped <= 1'b0;
            r_err     <= 1'b0;
        end else if (i_step) begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_bal     <= n_bal;
            r_stopped <= n_stopped;
            r_err     <= n_err;
        end
    end

    // a closed range leaves no state behind
    a_range_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last_byte) |=> (r_bal == '0 && r_pending == 2'd0 && !r_err))
        else $error("state not cleared after range end");

    // once decoding has stopped no code point is in progress
    a_stop_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_pending == 2'd0))
        else $error("code point pending after stop");

    // after a lead error nothing more is gathered
    a_err_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_pending == 2'd0))
        else $error("code point pending after lead error");

endmodule

`default_nettype wire

FILE: tb/sv/utf8_range_checker.sv
`timescale 1ns / 1ps
// scoreboard for the utf-8 byte range decoder: watches both channels, predicts and compares results
module utf8_range_checker
    import utf8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,   // last_byte
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [23:0] i_m_axis_tdata,   // [20:0] code_point, [21] has_code, [23:22] status
    input  wire logic        i_m_axis_tlast,   // range_end
    output int               o_fail_count,
    output int               o_outstanding,
    output int               o_results_checked
);

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              has_code;
        t_status           status;
        logic              range_end;
    } t_decoded;

    t_decoded          awaited_results[$];

    // decoder state as the predictor sees it
    logic [1:0]        cont_left;
    logic [CODE_W-1:0] code_acc;
    logic [BAL_W-1:0]  len_balance;
    logic              stopped;
    logic              lead_err;

    function automatic void clear_range_state();
        cont_left   = '0;
        code_acc    = '0;
        len_balance = '0;
        stopped     = 1'b0;
        lead_err    = 1'b0;
    endfunction

    // advances the state by one byte, returns 1 when the byte yields a result
    function automatic bit decode_byte(input logic [7:0] b, input logic is_last,
                                       output t_decoded res);
        logic [2:0]        announced;
        logic [CODE_W-1:0] code;
        bit                has;
        bit                emit;
        t_status           st;
        casez (b)
            8'b0???????: announced = 3'd1;
            8'b110?????: announced = 3'd2;
            8'b1110????: announced = 3'd3;
            8'b11110???: announced = 3'd4;
            default:     announced = 3'd0;
        endcase
        code = '0;
        has  = 1'b0;
        emit = 1'b0;

        if (b == 8'h00)
            stopped = 1'b1;
        // balance wraps at its own width
        if (!stopped && announced != 3'd0)
            len_balance = len_balance + BAL_W'(announced);
        len_balance = len_balance - BAL_W'(1);

        if (stopped) begin
            cont_left = '0;
            code_acc  = '0;
        end else if (!lead_err) begin
            if (cont_left != 2'd0) begin
                code_acc  = {code_acc[CODE_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    has      = 1'b1;
                    code     = code_acc;
                    code_acc = '0;
                end
            end else if (announced == 3'd0) begin
                lead_err = 1'b1;
                emit     = 1'b1;
            end else begin
                case (announced)
                    3'd1:    code_acc = CODE_W'(b[6:0]);
                    3'd2:    code_acc = CODE_W'(b[4:0]);
                    3'd3:    code_acc = CODE_W'(b[3:0]);
                    default: code_acc = CODE_W'(b[2:0]);
                endcase
                if (announced == 3'd1) begin
                    has      = 1'b1;
                    code     = code_acc;
                    code_acc = '0;
                end else begin
                    cont_left = 2'(announced - 3'd1);
                end
            end
        end

        emit = emit | has;
        if (is_last) begin
            if (len_balance != '0 || cont_left != 2'd0)
                st = STATUS_LEN_ERR;
            else
                st = lead_err ? STATUS_LEAD_ERR : STATUS_OK;
            emit = 1'b1;
        end else begin
            st = lead_err ? STATUS_LEAD_ERR : STATUS_OK;
        end

        res.code_point = code;
        res.has_code   = has;
        res.status     = st;
        res.range_end  = is_last;
        if (is_last)
            clear_range_state();
        return emit;
    endfunction

    initial clear_range_state();

    always @(posedge i_clk) begin
        t_decoded want;
        t_decoded seen;
        int       fails;
        int       checked;
        fails   = o_fail_count;
        checked = o_results_checked;
        if (!i_rst_n) begin
            awaited_results.delete();
            clear_range_state();
        end else begin
            // a result taken at this edge belongs to an earlier byte
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen.code_point = i_m_axis_tdata[20:0];
                seen.has_code   = i_m_axis_tdata[21];
                seen.status     = t_status'(i_m_axis_tdata[23:22]);
                seen.range_end  = i_m_axis_tlast;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, seen);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (seen.code_point !== want.code_point) begin
                        $display("%0t: code_point expected %h got %h",
                                 $time, want.code_point, seen.code_point);
                        fails++;
                    end
                    if (seen.has_code !== want.has_code) begin
                        $display("%0t: has_code expected %b got %b",
                                 $time, want.has_code, seen.has_code);
                        fails++;
                    end
                    if (seen.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, seen.status);
                        fails++;
                    end
                    if (seen.range_end !== want.range_end) begin
                        $display("%0t: range_end expected %b got %b",
                                 $time, want.range_end, seen.range_end);
                        fails++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (decode_byte(i_s_axis_tdata, i_s_axis_tlast, want))
                    awaited_results.push_back(want);
            end
        end
        o_fail_count      <= fails;
        o_results_checked <= checked;
        o_outstanding     <= awaited_results.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the utf-8 byte range decoder testbench: clock, reset, byte stimulus and verdict
module tb_top;

    localparam int BYTE_TARGET = 1100;
    localparam int LONG_HOLD   = 40;     // receiver hold-off, in cycles
    localparam int DRAIN_LIMIT = 2000;   // cycles allowed for the final results

    logic        i_clk;
    logic        i_rst_n = 1'b0;

    // slave side, driven by the byte sender
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'h00;        // [7:0] data_byte
    logic        s_last  = 1'b0;         // last_byte
    wire logic   s_ready;

    // master side, drained by the result receiver
    wire logic        m_valid;
    logic             m_ready = 1'b0;
    wire logic [23:0] m_data;            // [20:0] code_point, [21] has_code, [23:22] status
    wire logic        m_last;            // range_end

    int fail_count;
    int outstanding;
    int results_checked;

    // sender and receiver controls
    bit no_gaps      = 1'b0;             // both sides run back to back while set
    bit hold_request = 1'b0;             // receiver holds off once when set
    int bytes_sent   = 0;
    int ranges_sent  = 0;

    logic [7:0] range_bytes[$];          // bytes of the range about to be sent

    utf8_byte_range_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    utf8_range_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_axis_tvalid   (s_valid),
        .i_s_axis_tready   (s_ready),
        .i_s_axis_tdata    (s_data),
        .i_s_axis_tlast    (s_last),
        .i_m_axis_tvalid   (m_valid),
        .i_m_axis_tready   (m_ready),
        .i_m_axis_tdata    (m_data),
        .i_m_axis_tlast    (m_last),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // offers one item, waits a random gap first, returns once it is taken
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= is_last;
        do @(posedge i_clk); while (!s_ready);
        bytes_sent++;
    endtask

    // sends range_bytes as one range, tlast on the final byte
    task automatic send_range();
        for (int i = 0; i < range_bytes.size(); i++)
            send_byte(range_bytes[i], i == range_bytes.size() - 1);
        ranges_sent++;
    endtask

    // sender stops offering until every awaited result has been taken
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // appends one well-formed sequence of 1 to 4 bytes with random payload
    task automatic push_code_point(input int len);
        case (len)
            1:       range_bytes.push_back(8'($urandom_range(1, 127)));
            2:       range_bytes.push_back({3'b110, 5'($urandom)});
            3:       range_bytes.push_back({4'b1110, 4'($urandom)});
            default: range_bytes.push_back({5'b11110, 3'($urandom)});
        endcase
        for (int i = 1; i < len; i++)
            range_bytes.push_back({2'b10, 6'($urandom)});
    endtask

    // mostly well-formed ranges; one in five gets broken in some way
    task automatic build_random_range();
        int n;
        int idx;
        range_bytes.delete();
        n = $urandom_range(1, 8);
        repeat (n) push_code_point($urandom_range(1, 4));
        if ($urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, range_bytes.size() - 1);
            case ($urandom_range(0, 3))
                0: range_bytes[idx] = 8'($urandom);           // any byte anywhere
                1: range_bytes.insert(idx, 8'h00);            // zero byte stops decoding
                2: begin                                      // drop the final byte of the range
                    void'(range_bytes.pop_back());
                    if (range_bytes.size() == 0)
                        range_bytes.push_back(8'($urandom));
                end
                default: repeat ($urandom_range(1, 4))       // trailing noise
                    range_bytes.push_back(8'($urandom));
            endcase
        end
    endtask

    // result receiver: random stalls per item, one long hold-off on request
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 3);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    // hard limit on the run
    initial begin
        #2ms;
        $display("timeout: %0d results still awaited", outstanding);
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        bit stall_done;
        bit pause_done;
        int guard;
        stall_done = 1'b0;
        pause_done = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ascii edges, two- and three-byte sequences, clean range
        range_bytes = '{8'h41, 8'h7F, 8'hC2, 8'hBF, 8'hE2, 8'h82, 8'hAC};
        send_range();
        // largest four-byte payload, no range check on the value
        range_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_range();
        // continuation byte in lead position
        range_bytes = '{8'h80, 8'h41};
        send_range();
        // 11111xxx in lead position, alone in its range
        range_bytes = '{8'hF8};
        send_range();
        // zero byte drops the partial code and stops decoding
        range_bytes = '{8'hC3, 8'h00, 8'h41};
        send_range();
        // following bytes carrying lead patterns upset the balance
        range_bytes = '{8'hE0, 8'hC0, 8'h41};
        send_range();
        // range ends inside a code point
        range_bytes = '{8'hC3};
        send_range();
        // lone zero byte
        range_bytes = '{8'h00};
        send_range();
        wait_results_drained();

        while (bytes_sent < BYTE_TARGET) begin
            if (!stall_done && bytes_sent > 400) begin
                // receiver holds off while ascii bytes keep coming back to back
                stall_done   = 1'b1;
                hold_request = 1'b1;
                no_gaps      = 1'b1;
                range_bytes.delete();
                repeat (24) push_code_point(1);
                send_range();
            end
            if (!pause_done && bytes_sent > 700) begin
                pause_done = 1'b1;
                wait_results_drained();
            end
            no_gaps = ($urandom_range(0, 5) == 0);
            build_random_range();
            send_range();
        end
        s_valid <= 1'b0;

        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (outstanding != 0 && guard < DRAIN_LIMIT);
        repeat (5) @(posedge i_clk);

        $display("summary: %0d bytes in %0d ranges, %0d results compared",
                 bytes_sent, ranges_sent, results_checked);
        $display("summary: lead errors, zero bytes, truncated and noisy ranges, long output stall");
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: utf8_byte_range_decoder.f
hdl/utf8d_pkg.sv
hdl/utf8d_core.sv
hdl/utf8_byte_range_decoder.sv
tb/sv/utf8_range_checker.sv
tb/sv/tb_top.sv
